@@ sv/pls_pkg.sv @@
// ============================================================================
// pls_pkg: shared types and constants of the positional list store
// Beat layouts, operation and status codes, and the per-cell control bundle.
// ============================================================================
package pls_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = 8;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_MODIFY = 2'd1;
    localparam logic [1:0] MODE_INSERT = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_out;
        logic [1:0]               status;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
    } out_beat_t;

    // Broadcast to every cell; only set for a request that takes effect.
    typedef struct packed {
        logic              do_ins;
        logic              do_rem;
        logic              do_mod;
        logic [POS_W-1:0]  pos_idx;
        logic [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

@@ sv/pls_cell.sv @@
// ============================================================================
// pls_cell: one slot of the list
// Holds one word; takes its left or right neighbour's word on insert/remove.
// ============================================================================
module pls_cell (
    input  logic                       clk,
    input  logic [pls_pkg::POS_W-1:0]  idx,
    input  pls_pkg::cell_ctrl_t        ctrl,
    input  logic [pls_pkg::WORD_W-1:0] left_data,
    input  logic [pls_pkg::WORD_W-1:0] right_data,
    output logic [pls_pkg::WORD_W-1:0] data,
    output logic [pls_pkg::WORD_W-1:0] rd_data
);

    logic [pls_pkg::WORD_W-1:0] data_reg;
    logic [pls_pkg::WORD_W-1:0] data_next;
    logic                       hit;

    assign hit = (idx == ctrl.pos_idx);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.do_ins)
        begin
            // open the slot: later cells take the left neighbour
            if (idx > ctrl.pos_idx)
            begin
                data_next = left_data;
            end
            else if (hit)
            begin
                data_next = ctrl.value;
            end
        end
        else if (ctrl.do_rem)
        begin
            // close the slot: pull the right neighbour forward
            if (idx >= ctrl.pos_idx)
            begin
                data_next = right_data;
            end
        end
        else if (ctrl.do_mod && hit)
        begin
            data_next = ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = hit ? data_reg : '0;

endmodule

@@ sv/positional_list_store_top.sv @@
// ============================================================================
// positional_list_store_top: bounded ordered list with positional access
// Read, modify, insert and remove by 1-based position over a row of cells.
// ============================================================================
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+----------------------------------
//  in      | request   | in_valid/in_stall   | mode, position, value_in
//  out     | result    | out_valid/out_stall | value_out, status, count, is_empty
//
//  For every request all cells shift, write or are read in parallel, and the
//  result lands in the output register at the same edge as the cell update.
//  Sustained rate is one request per cycle while the output is taken.
//  A stalled output holds the request side off until its beat is taken.
//  Reset clears the entry count and the output valid; the cell words are
//  not cleared, since no position past the count is ever read.
//
module positional_list_store_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pls_pkg::in_beat_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pls_pkg::out_beat_t  out_data
);

    localparam int CMP_W = pls_pkg::POS_W + 1;

    logic [pls_pkg::CNT_W-1:0]  count_reg;
    logic [pls_pkg::CNT_W-1:0]  count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    pls_pkg::out_beat_t         out_data_reg;
    pls_pkg::out_beat_t         out_data_next;

    logic                       accept;
    logic [CMP_W-1:0]           pos_ext;
    logic [CMP_W-1:0]           cnt_ext;
    logic                       in_range;
    logic                       ins_range;
    logic                       full;
    logic                       ins_ok;
    logic                       rem_ok;
    logic                       mod_ok;
    pls_pkg::cell_ctrl_t        ctrl;
    logic [pls_pkg::WORD_W-1:0] rd_word;

    logic [pls_pkg::WORD_W-1:0] cell_data [pls_pkg::CAPACITY];
    logic [pls_pkg::WORD_W-1:0] cell_rd   [pls_pkg::CAPACITY];

    // Hold requests while a finished beat waits on the output.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Position checks against the count before this request.
    assign pos_ext   = CMP_W'(in_data.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign in_range  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign ins_range = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign full      = (count_reg == pls_pkg::CNT_W'(pls_pkg::CAPACITY));

    assign ins_ok = accept && (in_data.mode == pls_pkg::MODE_INSERT) && !full && ins_range;
    assign rem_ok = accept && (in_data.mode == pls_pkg::MODE_REMOVE) && in_range;
    assign mod_ok = accept && (in_data.mode == pls_pkg::MODE_MODIFY) && in_range;

    // Broadcast the request to the row.
    always_comb
    begin
        ctrl.do_ins  = ins_ok;
        ctrl.do_rem  = rem_ok;
        ctrl.do_mod  = mod_ok;
        ctrl.pos_idx = in_data.position - pls_pkg::POS_W'(1);
        ctrl.value   = in_data.value_in;
    end

    // Row of cells; each sees its left and right neighbour.
    for (genvar i = 0; i < pls_pkg::CAPACITY; i++)
    begin : g_cell
        logic [pls_pkg::WORD_W-1:0] left_w;
        logic [pls_pkg::WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == pls_pkg::CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        pls_cell u_cell (
            .clk        (clk),
            .idx        (pls_pkg::POS_W'(i)),
            .ctrl       (ctrl),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Merge the read taps; at most one cell matches the position.
    always_comb
    begin
        rd_word = '0;
        for (int k = 0; k < pls_pkg::CAPACITY; k++)
        begin
            rd_word = rd_word | cell_rd[k];
        end
    end

    // Count after this request and the result beat.
    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + pls_pkg::CNT_W'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - pls_pkg::CNT_W'(1);
        end

        out_data_next           = out_data_reg;
        out_valid_next          = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next          = 1'b1;
            out_data_next.value_out = '0;
            out_data_next.status    = pls_pkg::ST_OK;
            out_data_next.count     = count_next;
            out_data_next.is_empty  = (count_next == '0);
            case (in_data.mode)
                pls_pkg::MODE_READ:
                begin
                    if (in_range)
                    begin
                        out_data_next.value_out = rd_word;
                    end
                    else
                    begin
                        out_data_next.value_out = '1;
                        out_data_next.status    = pls_pkg::ST_BADPOS;
                    end
                end
                pls_pkg::MODE_INSERT:
                begin
                    if (full)
                    begin
                        out_data_next.status = pls_pkg::ST_FULL;
                    end
                    else if (!ins_range)
                    begin
                        out_data_next.status = pls_pkg::ST_BADPOS;
                    end
                end
                pls_pkg::MODE_MODIFY,
                pls_pkg::MODE_REMOVE:
                begin
                    if (!in_range)
                    begin
                        out_data_next.status = pls_pkg::ST_BADPOS;
                    end
                end
                default:
                begin
                    out_data_next.status = pls_pkg::ST_BADPOS;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ sv/pls_checker.sv @@
// ============================================================================
// pls_checker: port-level checks of the positional list store
// Watches the request and result channels and the reported count.
// ============================================================================
module pls_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input pls_pkg::out_beat_t out_data
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Every accepted request gives a result beat on the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request produced no result");

    // Empty flag agrees with the count.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.is_empty == (out_data.count == '0)))
        else $error("is_empty disagrees with count");

    // Full status only when the store is at capacity.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == pls_pkg::ST_FULL)
            |-> (out_data.count == pls_pkg::CNT_W'(pls_pkg::CAPACITY)))
        else $error("full status below capacity");

    // Count moves by at most one between consecutive fresh beats.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall ##1 out_valid |->
            (out_data.count == $past(out_data.count))
            || (out_data.count == $past(out_data.count) + pls_pkg::CNT_W'(1))
            || (out_data.count == $past(out_data.count) - pls_pkg::CNT_W'(1)))
        else $error("count jumped by more than one");

endmodule

bind positional_list_store_top pls_checker u_pls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for positional_list_store_top
// Sends read, modify, insert and remove requests across the valid/stall
// channels, predicts each result from a shadow copy of the list and checks
// every result beat field by field, in order.
// ============================================================================
module tb;
    import pls_pkg::*;

    localparam int ITEM_TARGET    = 1150;
    localparam int WATCHDOG_LIMIT = 1000;  // far above any legal quiet stretch
    localparam int LONG_HOLD      = 150;   // receiver hold-off for the backpressure burst
    localparam int SETTLE_CYCLES  = 8;

    // One row of the directed table: the request, and where it can be read off
    // at a glance, the result typed in by hand.
    typedef struct {
        in_beat_t  req;
        bit        typed;
        out_beat_t want;
    } directed_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;

    // Shadow of the list held by the block.
    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int                       list_len = 0;

    out_beat_t     expected_beats [$];
    directed_row_t directed_rows [$];

    int items_sent       = 0;
    bit sender_idle_on   = 1'b1;
    bit receiver_idle_on = 1'b1;
    int pressure_asks    = 0;   // bumped by the sender to ask for a long hold-off
    int pressure_seen    = 0;
    int stall_left       = 0;
    int hold_left        = 0;
    int quiet_cycles     = 0;
    bit mismatch_seen    = 1'b0;

    positional_list_store_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one request to the shadow list and return its result.
    // ------------------------------------------------------------------------
    function automatic out_beat_t list_op_result(input in_beat_t req);
        out_beat_t res;
        int        p;
        int        i;
        bit        in_range;
        res      = '0;
        p        = int'(req.position);
        in_range = (p >= 1) && (p <= list_len);
        case (req.mode)
            MODE_READ:
            begin
                if (in_range)
                    res.value_out = list_words[p-1];
                else
                begin
                    res.value_out = -1;
                    res.status    = ST_BADPOS;
                end
            end
            MODE_MODIFY:
            begin
                if (in_range)
                    list_words[p-1] = req.value_in;
                else
                    res.status = ST_BADPOS;
            end
            MODE_INSERT:
            begin
                // A full list refuses every insert, whatever the position.
                if (list_len >= CAPACITY)
                    res.status = ST_FULL;
                else if (p < 1 || p > list_len + 1)
                    res.status = ST_BADPOS;
                else
                begin
                    for (i = list_len; i > p - 1; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p-1] = req.value_in;
                    list_len++;
                end
            end
            default:
            begin
                if (in_range)
                begin
                    for (i = p - 1; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
                else
                    res.status = ST_BADPOS;
            end
        endcase
        res.count    = CNT_W'(list_len);
        res.is_empty = (list_len == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -1;
            3:       return 0;
            default: return $urandom;
        endcase
    endfunction

    // A request whose position is legal for the current list length, but for a non-insert on an empty list.
    function automatic in_beat_t well_formed_item(input logic [1:0] mode);
        in_beat_t req;
        req.mode     = mode;
        req.value_in = pick_word();
        if (mode == MODE_INSERT)
            req.position = 8'($urandom_range(1, list_len + 1));
        else if (list_len == 0)
            req.position = 8'($urandom_range(0, 255));
        else
            req.position = 8'($urandom_range(1, list_len));
        return req;
    endfunction

    // Any mode, any position: mostly out of range, covers the upper position bits.
    function automatic in_beat_t noise_item();
        in_beat_t req;
        req.mode     = 2'($urandom_range(0, 3));
        req.position = 8'($urandom_range(0, 255));
        req.value_in = $urandom;
        return req;
    endfunction

    function automatic int sender_gap();
        return sender_idle_on ? int'($urandom_range(0, 11)) : 0;
    endfunction

    task automatic add_row(input logic [1:0] mode, input int pos,
                           input logic signed [WORD_W-1:0] val, input bit typed,
                           input logic signed [WORD_W-1:0] want_value,
                           input logic [1:0] want_status, input int want_count);
        directed_row_t row;
        row.req.mode       = mode;
        row.req.position   = pos[POS_W-1:0];
        row.req.value_in   = val;
        row.typed          = typed;
        row.want.value_out = want_value;
        row.want.status    = want_status;
        row.want.count     = CNT_W'(want_count);
        row.want.is_empty  = (want_count == 0);
        directed_rows.push_back(row);
    endtask

    // Offer one request after an idle gap; hold it until accepted, then
    // record what the block owes for it.
    task automatic issue_request(input in_beat_t req, input int gap, input bit typed,
                                 input out_beat_t want);
        out_beat_t predicted;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = list_op_result(req);
        expected_beats.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_random(input in_beat_t req);
        issue_request(req, sender_gap(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: check each taken beat against the oldest expectation.
    // ------------------------------------------------------------------------
    task automatic check_beat(input out_beat_t got);
        out_beat_t want;
        if (expected_beats.size() == 0)
        begin
            $display("%0t: result beat with nothing expected: value_out %0d status %0d "
                     , $time, got.value_out, got.status,
                     "count %0d is_empty %0b", got.count, got.is_empty);
            mismatch_seen = 1'b1;
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got.value_out !== want.value_out)
            begin
                $display("%0t: value_out expected %0d got %0d",
                         $time, want.value_out, got.value_out);
                mismatch_seen = 1'b1;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                mismatch_seen = 1'b1;
            end
            if (got.count !== want.count)
            begin
                $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
                mismatch_seen = 1'b1;
            end
            if (got.is_empty !== want.is_empty)
            begin
                $display("%0t: is_empty expected %0b got %0b",
                         $time, want.is_empty, got.is_empty);
                mismatch_seen = 1'b1;
            end
        end
    endtask

    // Receiver: after each taken beat draw a random stall while receiver idling is
    // on; on request from the sender hold off for a long stretch so the block backs up.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            check_beat(out_data);
            stall_left = receiver_idle_on ? int'($urandom_range(0, 11)) : 0;
        end
        if (pressure_seen != pressure_asks)
        begin
            pressure_seen = pressure_asks;
            hold_left     = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("positional_list_store_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase_kind;
        in_beat_t req;

        // Directed table. The empty list, the first inserts and their read, and the
        // obvious error codes are typed in; the rest, which depends on list contents, goes to the predictor.
        add_row(MODE_READ,   0,   0,             1, -1, ST_BADPOS, 0);
        add_row(MODE_READ,   1,   0,             1, -1, ST_BADPOS, 0);
        add_row(MODE_MODIFY, 1,   32'h5A5A_5A5A, 1, 0,  ST_BADPOS, 0);
        add_row(MODE_REMOVE, 1,   0,             1, 0,  ST_BADPOS, 0);
        add_row(MODE_INSERT, 0,   7,             1, 0,  ST_BADPOS, 0);
        add_row(MODE_INSERT, 2,   7,             1, 0,  ST_BADPOS, 0);
        add_row(MODE_INSERT, 1,   32'h7FFF_FFFF, 1, 0,  ST_OK,     1);
        add_row(MODE_READ,   1,   0,             1, 32'h7FFF_FFFF, ST_OK, 1);
        add_row(MODE_INSERT, 2,   32'h8000_0000, 1, 0,  ST_OK,     2);  // append at tail
        add_row(MODE_INSERT, 1,   -1,            1, 0,  ST_OK,     3);  // push at head
        add_row(MODE_INSERT, 2,   1,             0, 0,  ST_OK,     0);  // open a slot mid-list
        add_row(MODE_READ,   1,   0,             0, 0,  ST_OK,     0);
        add_row(MODE_READ,   2,   0,             0, 0,  ST_OK,     0);
        add_row(MODE_READ,   4,   0,             0, 0,  ST_OK,     0);
        add_row(MODE_READ,   5,   0,             1, -1, ST_BADPOS, 4);
        add_row(MODE_READ,   255, 0,             1, -1, ST_BADPOS, 4);
        add_row(MODE_INSERT, 255, 3,             1, 0,  ST_BADPOS, 4);
        add_row(MODE_MODIFY, 4,   32'hDEAD_BEEF, 0, 0,  ST_OK,     0);
        add_row(MODE_MODIFY, 5,   9,             1, 0,  ST_BADPOS, 4);
        add_row(MODE_REMOVE, 0,   0,             1, 0,  ST_BADPOS, 4);
        add_row(MODE_REMOVE, 5,   0,             1, 0,  ST_BADPOS, 4);
        add_row(MODE_REMOVE, 2,   0,             0, 0,  ST_OK,     0);  // close a mid-list slot
        add_row(MODE_READ,   2,   0,             0, 0,  ST_OK,     0);
        add_row(MODE_REMOVE, 3,   0,             0, 0,  ST_OK,     0);  // drop the tail
        add_row(MODE_READ,   3,   0,             0, 0,  ST_OK,     0);

        // Hold reset, then release it at an edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            issue_request(directed_rows[r].req, sender_gap(), directed_rows[r].typed,
                          directed_rows[r].want);

        // Backpressure burst: ask for a long hold-off and keep offering beats
        // back to back, so the block fills and stalls its input.
        pressure_asks++;
        sender_idle_on = 1'b0;
        repeat (40)
            send_random(well_formed_item(2'($urandom_range(0, 3))));

        // Random phases: fill to the brim, drain to empty, or mixed traffic.
        while (items_sent < ITEM_TARGET)
        begin
            sender_idle_on   = ($urandom_range(0, 3) != 0);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
            phase_kind       = $urandom_range(0, 3);
            case (phase_kind)
                0:
                begin
                    while (list_len < CAPACITY)
                        send_random(($urandom_range(0, 6) == 0) ? noise_item()
                                                              : well_formed_item(MODE_INSERT));
                    // Knock on the full list at random positions.
                    repeat ($urandom_range(2, 6))
                    begin
                        req      = noise_item();
                        req.mode = MODE_INSERT;
                        send_random(req);
                    end
                end
                1:
                begin
                    while (list_len > 0)
                        send_random(($urandom_range(0, 6) == 0) ? noise_item()
                                                              : well_formed_item(MODE_REMOVE));
                    repeat (3)
                        send_random(noise_item());
                end
                default:
                begin
                    repeat ($urandom_range(20, 60))
                        send_random(($urandom_range(0, 4) == 0) ? noise_item()
                                    : well_formed_item(2'($urandom_range(0, 3))));
                end
            endcase
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed result, then settle for strays.
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (!mismatch_seen && expected_beats.size() == 0)
            $display("positional_list_store_top test passed");
        else
            $display("positional_list_store_top test failed");
        $finish;
    end

endmodule
